// File: rtl/dpp_pkg.sv
// Shared constants for the depth pixel to point back-projection block.
package dpp_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FOCAL_LENGTH = 2'd0;
    localparam logic [1:0] REG_CENTER_COL   = 2'd1;
    localparam logic [1:0] REG_CENTER_ROW   = 2'd2;

    // Register widths and reset values.
    localparam int FOCAL_BITS  = 12;
    localparam int CENTER_BITS = 10;
    localparam logic [FOCAL_BITS-1:0]  FOCAL_RESET = 12'd585;
    localparam logic [CENTER_BITS-1:0] COL_RESET   = 10'd320;
    localparam logic [CENTER_BITS-1:0] ROW_RESET   = 10'd240;

    // Depth codes that mean no measurement.
    localparam int DEPTH_BITS = 16;
    localparam logic [DEPTH_BITS-1:0] DEPTH_ZERO = 16'd0;
    localparam logic [DEPTH_BITS-1:0] DEPTH_NONE = 16'hFFFF;

    // Scale from millimetres to micrometres.
    localparam int UM_PER_MM = 1000;

    // Fraction bits of the square root result.
    localparam int ROOT_FRAC = 16;

    // Output field widths.
    localparam int XY_BITS = 27;
    localparam int Z_BITS  = 26;

    // Largest output magnitude in micrometres.
    localparam int MAX_UM = 65535000;

endpackage

// File: rtl/dpp_root_cell.sv
// One digit cell of the pipelined square root: takes two radicand bits per stage.
module dpp_root_cell #(
    parameter int RW = 29
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW+1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [1:0]    i_pair,
    output logic [RW+1:0] o_rem,
    output logic [RW-1:0] o_root
);

    logic [RW+3:0] w_cur;
    logic [RW+3:0] w_trial;
    logic [RW+1:0] n_rem;
    logic [RW-1:0] n_root;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;

    // Bring down two radicand bits and try to set the next root bit.
    always_comb begin
        w_cur   = {i_rem, i_pair};
        w_trial = {2'b00, i_root, 2'b01};
        if (w_cur >= w_trial) begin
            n_rem  = (RW+2)'(w_cur - w_trial);
            n_root = {i_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = w_cur[RW+1:0];
            n_root = {i_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// File: rtl/dpp_div_cell.sv
// One bit cell of the pipelined restoring divider: one quotient bit per stage.
module dpp_div_cell #(
    parameter int DW = 30,
    parameter int QB = 21
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,
    input  logic          i_bit,
    input  logic [DW-1:0] i_div,
    input  logic [QB-1:0] i_q,
    output logic [DW-1:0] o_rem,
    output logic [QB-1:0] o_q
);

    logic [DW:0]   w_cur;
    logic [DW-1:0] n_rem;
    logic [QB-1:0] n_q;
    logic [DW-1:0] r_rem;
    logic [QB-1:0] r_q;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        w_cur = {i_rem, i_bit};
        if (w_cur >= {1'b0, i_div}) begin
            n_rem = DW'(w_cur - {1'b0, i_div});
            n_q   = {i_q[QB-2:0], 1'b1};
        end else begin
            n_rem = w_cur[DW-1:0];
            n_q   = {i_q[QB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rem = r_rem;
    assign o_q   = r_q;

endmodule

// File: rtl/depth_pixel_to_point.sv
// Stages in order: input, squares, sum, root chain, divider chains, product, output.
// RW is the root width, half of the widened radicand, 29 bits by default.
// Throughput: one pixel per cycle; the root and divider cell chains each hold one pixel
// per cell and all stages advance together unless the output register is stalled.
// Reset (synchronous, active low) empties the pipeline and loads the default intrinsics.
module depth_pixel_to_point #(
    parameter int PIXEL_BITS    = 10,
    parameter int FRACTION_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // pixel_col, pixel_row, depth_mm from bit 0 up, zero padded to whole bytes.
    input  logic [((2*PIXEL_BITS+16+7)/8)*8-1:0] i_s_axis_tdata,
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // point_x_um, point_y_um, point_z_um from bit 0 up.
    output logic [79:0] o_m_axis_tdata,
    // point_valid.
    output logic        o_m_axis_tuser,
    // Configuration port.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int PB   = PIXEL_BITS;
    localparam int FB   = FRACTION_BITS;
    localparam int CW   = (PB > 12) ? PB : 12;
    localparam int SW   = ((2*PB+1 > 24) ? 2*PB+1 : 24) + 1;
    localparam int RW   = (SW + 2*dpp_pkg::ROOT_FRAC + 1) / 2;
    localparam int QB   = FB + 1;
    localparam int DW   = RW + 1;
    localparam int NW   = (RW > QB) ? RW : QB;
    localparam int TW   = 16 + QB;
    localparam int PW   = TW + 10;

    typedef struct packed {
        logic          vld;
        logic          miss;
        logic          negx;
        logic          negy;
        logic [15:0]   depth;
        logic [CW-1:0] adu;
        logic [CW-1:0] adv;
        logic [CW-1:0] foc;
    } t_pass;

    typedef struct packed {
        logic          vld;
        logic          miss;
        logic          negx;
        logic          negy;
        logic [15:0]   depth;
    } t_tail;

    // Configuration registers.
    logic [11:0] r_focal;
    logic [9:0]  r_ccol;
    logic [9:0]  r_crow;
    logic        w_cfg_wr;

    assign w_cfg_wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= dpp_pkg::FOCAL_RESET;
            r_ccol  <= dpp_pkg::COL_RESET;
            r_crow  <= dpp_pkg::ROW_RESET;
        end else if (w_cfg_wr) begin
            unique case (i_paddr[3:2])
                dpp_pkg::REG_FOCAL_LENGTH: r_focal <= i_pwdata[11:0];
                dpp_pkg::REG_CENTER_COL:   r_ccol  <= i_pwdata[9:0];
                dpp_pkg::REG_CENTER_ROW:   r_crow  <= i_pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (i_paddr[3:2])
            dpp_pkg::REG_FOCAL_LENGTH: o_prdata = {20'd0, r_focal};
            dpp_pkg::REG_CENTER_COL:   o_prdata = {22'd0, r_ccol};
            dpp_pkg::REG_CENTER_ROW:   o_prdata = {22'd0, r_crow};
            default:                   o_prdata = 32'd0;
        endcase
    end

    // All stages move together whenever the output register can take a result.
    logic w_en;
    logic r_out_vld;

    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Input stage: offsets from the principal point, their signs, missing depth.
    logic [PB-1:0] w_col, w_row, w_cc, w_cr;
    logic [15:0]   w_dep;
    t_pass         n_p0, r_p0;

    always_comb begin
        w_col = i_s_axis_tdata[PB-1:0];
        w_row = i_s_axis_tdata[2*PB-1:PB];
        w_dep = i_s_axis_tdata[2*PB+15:2*PB];
        w_cc  = PB'({{(CW-10){1'b0}}, r_ccol});
        w_cr  = PB'({{(CW-10){1'b0}}, r_crow});
        n_p0.vld   = i_s_axis_tvalid;
        n_p0.miss  = (w_dep == dpp_pkg::DEPTH_ZERO) || (w_dep == dpp_pkg::DEPTH_NONE);
        n_p0.negx  = w_col < w_cc;
        n_p0.negy  = w_row < w_cr;
        n_p0.depth = w_dep;
        n_p0.adu   = CW'(n_p0.negx ? w_cc - w_col : w_col - w_cc);
        n_p0.adv   = CW'(n_p0.negy ? w_cr - w_row : w_row - w_cr);
        n_p0.foc   = CW'((r_focal == 12'd0) ? 12'd1 : r_focal);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0.vld <= 1'b0;
        end else if (w_en) begin
            r_p0 <= n_p0;
        end
    end

    // Squares of the focal length and of both offsets.
    t_pass           r_p1;
    logic [2*CW-1:0] r_sqf, r_squ, r_sqv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.vld <= 1'b0;
        end else if (w_en) begin
            r_p1  <= r_p0;
            r_sqf <= r_p0.foc * r_p0.foc;
            r_squ <= r_p0.adu * r_p0.adu;
            r_sqv <= r_p0.adv * r_p0.adv;
        end
    end

    // Sum of squares, the radicand of the ray length.
    t_pass         w_sp [RW+1];
    logic [SW-1:0] w_ss [RW+1];
    t_pass         r_p2;
    logic [SW-1:0] r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2.vld <= 1'b0;
        end else if (w_en) begin
            r_p2 <= r_p1;
            r_s  <= SW'(r_sqf) + SW'(r_squ) + SW'(r_sqv);
        end
    end

    assign w_sp[0] = r_p2;
    assign w_ss[0] = r_s;

    // Square root chain: one cell per root bit.
    logic [RW+1:0] w_rrem  [RW+1];
    logic [RW-1:0] w_rroot [RW+1];

    assign w_rrem[0]  = '0;
    assign w_rroot[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_root
        logic [2*RW-1:0] w_rad;
        t_pass           r_pass;
        logic [SW-1:0]   r_sv;

        assign w_rad = {{(2*RW-SW){1'b0}}, w_ss[k]} << (2*dpp_pkg::ROOT_FRAC);

        dpp_root_cell #(.RW(RW)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rrem[k]),
            .i_root (w_rroot[k]),
            .i_pair (w_rad[2*(RW-1-k) +: 2]),
            .o_rem  (w_rrem[k+1]),
            .o_root (w_rroot[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pass.vld <= 1'b0;
            end else if (w_en) begin
                r_pass <= w_sp[k];
                r_sv   <= w_ss[k];
            end
        end

        assign w_sp[k+1] = r_pass;
        assign w_ss[k+1] = r_sv;
    end

    // Divider set-up: numerator c * 2^(F+17) + r over divisor 2r, rounding half up.
    logic [RW-1:0] w_root;
    logic [NW-1:0] w_rext;
    t_tail         w_dp [QB+1];
    logic [DW-1:0] w_dd [QB+1];
    logic [QB-1:0] w_dn [QB+1];
    logic [DW-1:0] w_drem [3][QB+1];
    logic [QB-1:0] w_dq   [3][QB+1];
    logic [CW-1:0] w_c    [3];

    assign w_root = w_rroot[RW];
    assign w_rext = NW'(w_root);
    assign w_c[0] = w_sp[RW].adu;
    assign w_c[1] = w_sp[RW].adv;
    assign w_c[2] = w_sp[RW].foc;

    assign w_dp[0].vld   = w_sp[RW].vld;
    assign w_dp[0].miss  = w_sp[RW].miss;
    assign w_dp[0].negx  = w_sp[RW].negx;
    assign w_dp[0].negy  = w_sp[RW].negy;
    assign w_dp[0].depth = w_sp[RW].depth;
    assign w_dd[0]       = {w_root, 1'b0};
    assign w_dn[0]       = w_rext[QB-1:0];

    for (genvar l = 0; l < 3; l++) begin : g_lane_init
        assign w_drem[l][0] = (DW'(w_c[l]) << dpp_pkg::ROOT_FRAC)
                            + DW'(w_root >> (FB + 1));
        assign w_dq[l][0]   = '0;
    end

    // Divider chains: one cell per quotient bit in each of the x, y and z lanes.
    for (genvar j = 0; j < QB; j++) begin : g_div
        t_tail         r_pass;
        logic [DW-1:0] r_dd;
        logic [QB-1:0] r_dn;

        for (genvar l = 0; l < 3; l++) begin : g_lane
            dpp_div_cell #(.DW(DW), .QB(QB)) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_rem (w_drem[l][j]),
                .i_bit (w_dn[j][QB-1-j]),
                .i_div (w_dd[j]),
                .i_q   (w_dq[l][j]),
                .o_rem (w_drem[l][j+1]),
                .o_q   (w_dq[l][j+1])
            );
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pass.vld <= 1'b0;
            end else if (w_en) begin
                r_pass <= w_dp[j];
                r_dd   <= w_dd[j];
                r_dn   <= w_dn[j];
            end
        end

        assign w_dp[j+1] = r_pass;
        assign w_dd[j+1] = r_dd;
        assign w_dn[j+1] = r_dn;
    end

    // Depth times ray ratio for each lane.
    t_tail         r_m1;
    logic [TW-1:0] r_t [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1.vld <= 1'b0;
        end else if (w_en) begin
            r_m1 <= w_dp[QB];
            for (int l = 0; l < 3; l++) begin
                r_t[l] <= TW'(w_dp[QB].depth * w_dq[l][QB]);
            end
        end
    end

    // Scale to micrometres, round, apply signs and the missing-depth rule.
    logic [PW-1:0]       w_p   [3];
    logic [25:0]         w_mag [3];
    logic [26:0]         n_x, n_y;
    logic [25:0]         n_z;
    logic [26:0]         r_x, r_y;
    logic [25:0]         r_z;
    logic                r_user;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_p[l]   = PW'(r_t[l]) * PW'(dpp_pkg::UM_PER_MM)
                     + (PW'(1) << (FB - 1));
            w_mag[l] = 26'(w_p[l] >> FB);
        end
        n_x = r_m1.negx ? 27'(-{1'b0, w_mag[0]}) : {1'b0, w_mag[0]};
        n_y = r_m1.negy ? 27'(-{1'b0, w_mag[1]}) : {1'b0, w_mag[1]};
        n_z = w_mag[2];
        if (r_m1.miss) begin
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_m1.vld;
            r_x       <= n_x;
            r_y       <= n_y;
            r_z       <= n_z;
            r_user    <= !r_m1.miss;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_z, r_y, r_x};
    assign o_m_axis_tuser  = r_user;

endmodule

// File: rtl/dpp_checker.sv
// Port-level checks of the depth pixel to point block, bound to the top level.
module dpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A stalled result transfer holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output payload changed while stalled");

    // An invalid point carries zero coordinates.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 80'd0)
        else $error("invalid point with nonzero coordinates");

    // z never exceeds the largest output magnitude in micrometres.
    a_zmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[79:54] <= 26'(dpp_pkg::MAX_UM))
        else $error("z out of range");

    // x magnitude never exceeds the largest output magnitude in micrometres.
    a_xmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[26:0]) <= $signed(27'(dpp_pkg::MAX_UM))) &&
            ($signed(o_m_axis_tdata[26:0]) >= -$signed(27'(dpp_pkg::MAX_UM))))
        else $error("x out of range");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (.*);

// File: tb/depth_pixel_to_point_tb.sv
// Testbench for depth_pixel_to_point: directed table and random pixels against a predictor.
module depth_pixel_to_point_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = 10;
    localparam int FB = 20;
    localparam int LATENCY = 60;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic                        valid;
        logic [dpp_pkg::XY_BITS-1:0] x;
        logic [dpp_pkg::XY_BITS-1:0] y;
        logic [dpp_pkg::Z_BITS-1:0]  z;
    } t_point;

    typedef struct {
        logic [PB-1:0] col;
        logic [PB-1:0] row;
        logic [15:0]   depth;
        bit            typed;
        t_point        pt;
    } t_pixel_row;

    logic i_clk, i_rst_n;
    logic i_s_axis_tvalid, o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic o_m_axis_tvalid, i_m_axis_tready;
    logic [79:0] o_m_axis_tdata;
    logic o_m_axis_tuser;
    logic i_psel, i_penable, i_pwrite;
    logic [3:0] i_paddr;
    logic [31:0] i_pwdata, o_prdata;
    logic o_pready;

    depth_pixel_to_point dut (.*);

    // Intrinsics as the block should hold them.
    logic [dpp_pkg::FOCAL_BITS-1:0]  cfg_focal;
    logic [dpp_pkg::CENTER_BITS-1:0] cfg_col, cfg_row;

    t_point expected_points[$];
    int errors;
    int idle_cycles;
    bit hold_off;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Bitwise integer square root.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= res + bit_v) begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Scaled magnitude: round(1000 * d * sat(round(c / sqrt(S)))).
    function automatic longint unsigned ray_um(input longint unsigned c, input longint unsigned r,
                                               input longint unsigned d);
        longint unsigned g;
        g = (2 * (c << (FB + dpp_pkg::ROOT_FRAC)) + r) / (2 * r);
        if (g > (64'd1 << FB)) g = 64'd1 << FB;
        return (dpp_pkg::UM_PER_MM * d * g + (64'd1 << (FB - 1))) >> FB;
    endfunction

    function automatic t_point project_pixel(input logic [PB-1:0] col, input logic [PB-1:0] row,
                                             input logic [15:0] depth);
        t_point p;
        longint unsigned f, adu, adv, r, xm, ym, zm;
        bit negx, negy;
        p = '0;
        if (depth == dpp_pkg::DEPTH_ZERO || depth == dpp_pkg::DEPTH_NONE) return p;
        f = cfg_focal == 0 ? 1 : cfg_focal;
        negx = col < cfg_col;
        negy = row < cfg_row;
        adu = negx ? cfg_col - col : col - cfg_col;
        adv = negy ? cfg_row - row : row - cfg_row;
        r = int_sqrt((f * f + adu * adu + adv * adv) << 32);
        xm = ray_um(adu, r, depth);
        ym = ray_um(adv, r, depth);
        zm = ray_um(f, r, depth);
        p.valid = 1'b1;
        p.x = negx ? dpp_pkg::XY_BITS'(-xm) : dpp_pkg::XY_BITS'(xm);
        p.y = negy ? dpp_pkg::XY_BITS'(-ym) : dpp_pkg::XY_BITS'(ym);
        p.z = dpp_pkg::Z_BITS'(zm);
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // Register write in setup and access cycles.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_psel = 1; i_penable = 0; i_pwrite = 1;
        i_paddr = {idx, 2'b00}; i_pwdata = value;
        @(negedge i_clk);
        i_penable = 1;
        @(negedge i_clk);
        i_psel = 0; i_penable = 0; i_pwrite = 0;
        case (idx)
            dpp_pkg::REG_FOCAL_LENGTH: cfg_focal = value[dpp_pkg::FOCAL_BITS-1:0];
            dpp_pkg::REG_CENTER_COL:   cfg_col = value[dpp_pkg::CENTER_BITS-1:0];
            dpp_pkg::REG_CENTER_ROW:   cfg_row = value[dpp_pkg::CENTER_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [PB-1:0] col, input logic [PB-1:0] row,
                              input logic [15:0] depth);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        repeat (gap) @(negedge i_clk);
        expected_points.insert(expected_points.size(), project_pixel(col, row, depth));
        i_s_axis_tdata = {4'b0, depth, row, col};
        i_s_axis_tvalid = 1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        i_s_axis_tvalid = 0;
    endtask

    task automatic drain();
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic random_pixels(input int n);
        logic [15:0] d;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: d = dpp_pkg::DEPTH_ZERO;
                1: d = dpp_pkg::DEPTH_NONE;
                2: d = 16'($urandom_range(1, 8));
                3: d = 16'hFFFE;
                default: d = 16'($urandom_range(1, 65534));
            endcase
            send_pixel(PB'($urandom), PB'($urandom), d);
        end
    endtask

    // Output side: a random wait before each transfer, one long hold-off on request.
    initial begin
        int wait_cycles;
        i_m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_m_axis_tready = 0;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            wait_cycles = $urandom_range(0, 10);
            if (wait_cycles != 0) begin
                i_m_axis_tready = 0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_m_axis_tready = 1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_point want, got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.valid = o_m_axis_tuser;
            got.x = o_m_axis_tdata[dpp_pkg::XY_BITS-1:0];
            got.y = o_m_axis_tdata[2*dpp_pkg::XY_BITS-1:dpp_pkg::XY_BITS];
            got.z = o_m_axis_tdata[2*dpp_pkg::XY_BITS+dpp_pkg::Z_BITS-1:2*dpp_pkg::XY_BITS];
            if (expected_points.size() == 0) begin
                report_mismatch("unexpected point", got.z, 0);
            end else begin
                want = expected_points.pop_front();
                if (got.valid !== want.valid) report_mismatch("valid", got.valid, want.valid);
                if (got.x !== want.x)
                    report_mismatch("x", $signed(got.x), $signed(want.x));
                if (got.y !== want.y)
                    report_mismatch("y", $signed(got.y), $signed(want.y));
                if (got.z !== want.z) report_mismatch("z", got.z, want.z);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    t_pixel_row directed[] = '{
        '{10'd320, 10'd240, 16'd1000, 1, '{1'b1, 27'd0, 27'd0, 26'd1000000}},
        '{10'd320, 10'd240, 16'd0, 1, '0},
        '{10'd0, 10'd0, 16'hFFFF, 1, '0},
        '{10'd320, 10'd240, 16'hFFFE, 1, '{1'b1, 27'd0, 27'd0, 26'd65534000}},
        '{10'd320, 10'd240, 16'd1, 1, '{1'b1, 27'd0, 27'd0, 26'd1000}},
        '{10'd0, 10'd0, 16'hFFFE, 0, '0},
        '{10'd1023, 10'd1023, 16'hFFFE, 0, '0},
        '{10'd1023, 10'd0, 16'd1, 0, '0},
        '{10'd0, 10'd1023, 16'd12345, 0, '0},
        '{10'd321, 10'd240, 16'd500, 0, '0},
        '{10'd320, 10'd239, 16'd500, 0, '0},
        '{10'd682, 10'd341, 16'hAAAA, 0, '0},
        '{10'd341, 10'd682, 16'h5555, 0, '0}
    };

    initial begin
        t_point p;
        errors = 0; idle_cycles = 0; hold_off = 0;
        i_rst_n = 0; i_s_axis_tvalid = 0; i_s_axis_tdata = '0;
        i_psel = 0; i_penable = 0; i_pwrite = 0; i_paddr = '0; i_pwdata = '0;
        cfg_focal = dpp_pkg::FOCAL_RESET;
        cfg_col = dpp_pkg::COL_RESET;
        cfg_row = dpp_pkg::ROW_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        // Directed table at reset intrinsics.
        foreach (directed[k]) begin
            if (directed[k].typed) begin
                p = project_pixel(directed[k].col, directed[k].row, directed[k].depth);
                if (p !== directed[k].pt) report_mismatch("table row", k, 0);
            end
            send_pixel(directed[k].col, directed[k].row, directed[k].depth);
        end
        drain();

        // Extreme intrinsics: zero focal length and corner principal point.
        write_reg(dpp_pkg::REG_FOCAL_LENGTH, 32'd0);
        write_reg(dpp_pkg::REG_CENTER_COL, 32'd0);
        write_reg(dpp_pkg::REG_CENTER_ROW, 32'd1023);
        send_pixel(10'd0, 10'd1023, 16'd1000);
        send_pixel(10'd1023, 10'd0, 16'hFFFE);
        random_pixels(200);
        drain();

        write_reg(dpp_pkg::REG_FOCAL_LENGTH, 32'd4095);
        write_reg(dpp_pkg::REG_CENTER_COL, 32'd1023);
        write_reg(dpp_pkg::REG_CENTER_ROW, 32'd0);
        random_pixels(300);
        drain();

        write_reg(dpp_pkg::REG_FOCAL_LENGTH, 32'd1);
        write_reg(dpp_pkg::REG_CENTER_COL, 32'd512);
        write_reg(dpp_pkg::REG_CENTER_ROW, 32'd512);
        random_pixels(300);
        drain();

        // Receiver holds off while pixels keep coming.
        write_reg(dpp_pkg::REG_FOCAL_LENGTH, 32'($urandom_range(1, 4095)));
        write_reg(dpp_pkg::REG_CENTER_COL, 32'($urandom));
        write_reg(dpp_pkg::REG_CENTER_ROW, 32'($urandom));
        hold_off = 1;
        random_pixels(450);
        drain();

        write_reg(dpp_pkg::REG_FOCAL_LENGTH, 32'd585);
        write_reg(dpp_pkg::REG_CENTER_COL, 32'd320);
        write_reg(dpp_pkg::REG_CENTER_ROW, 32'd240);
        random_pixels(500);
        drain();

        if (errors == 0 && expected_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dpp_pkg.sv
rtl/dpp_root_cell.sv
rtl/dpp_div_cell.sv
rtl/depth_pixel_to_point.sv
rtl/dpp_checker.sv
tb/depth_pixel_to_point_tb.sv
